FILE: rtl/core/edfdm_pkg.sv
// shared constants, types and codes of the edge frequency distance meter
`timescale 1ns / 1ps
package edfdm_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int TIME_W     = 32;
  localparam int EDGE_W     = 8;
  localparam int CNT_W      = 16;
  localparam int DIST_W     = 16;
  localparam int FREQ_W     = 16;
  localparam int DIV_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int TIME_SCALE_DEF    = 1000;
  localparam int NEAR_DISTANCE_DEF = 0;
  localparam int FAR_DISTANCE_DEF  = 1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE        = 3'd0,
    CFG_CUTOFF        = 3'd1,
    CFG_ENOUGH_EDGES  = 3'd2,
    CFG_SAMPLE_LIMIT  = 3'd3,
    CFG_FREQ_HI       = 3'd4,
    CFG_FREQ_LO       = 3'd5,
    CFG_LINEAR_OFFSET = 3'd6,
    CFG_SIGNAL_RANGE  = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_IVDIV,
    S_MUL,
    S_CMP,
    S_FDIV,
    S_OUT
  } seq_state_t;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] dur;
    logic [EDGE_W-1:0] edges;
  } win_close_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq_hi;
    logic [FREQ_W-1:0] freq_lo;
    logic [DIST_W-1:0] linear_offset;
    logic [DIST_W-1:0] signal_range;
  } seq_cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_stat_t;

endpackage

FILE: rtl/core/edfdm_div.sv
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module edfdm_div
  import edfdm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  div_req_t  req,
  output div_stat_t stat
);

  localparam int STEP_W = $clog2(DIV_W);

  logic [DIV_W:0]    rem_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DIV_W-1:0]  dsr_r, dsr_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_W:0]    rem_sh;
  logic [DIV_W:0]    rem_sub;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};
    rem_sub  = rem_sh - {1'b0, dsr_r};
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      step_nxt = STEP_W'(DIV_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dsr_r}) begin
        rem_nxt = rem_sub;
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign stat.done     = done_r;
  assign stat.quotient = quo_r;

endmodule

FILE: rtl/core/edfdm_window.sv
// measurement window tracking: edge counting, sample counting and close detection
`timescale 1ns / 1ps
module edfdm_window
  import edfdm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [TIME_W-1:0]   time_ms,
  input  logic                enable,
  input  logic [SAMPLE_W-1:0] cutoff,
  input  logic [EDGE_W-1:0]   enough_edges,
  input  logic [CNT_W-1:0]    sample_limit,
  output win_close_t          close
);

  logic                open_r, open_nxt;
  logic [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic [EDGE_W-1:0]   edges_r, edges_nxt;
  logic [CNT_W-1:0]    samp_r, samp_nxt;
  logic [TIME_W-1:0]   start_r, start_nxt;
  win_close_t          close_r, close_nxt;

  logic [SAMPLE_W-1:0] prev_base;
  logic [EDGE_W-1:0]   edges_base;
  logic [CNT_W-1:0]    samp_base;
  logic                hit;
  logic                closes;

  always_comb begin
    prev_base  = open_r ? prev_r  : '0;
    edges_base = open_r ? edges_r : '0;
    samp_base  = open_r ? samp_r  : '0;
    start_nxt  = open_r ? start_r : time_ms;
    hit        = (sample < cutoff) && (prev_base >= cutoff) && (edges_base != '1);
    edges_nxt  = edges_base + EDGE_W'(hit);
    samp_nxt   = samp_base + CNT_W'(samp_base != '1);
    prev_nxt   = sample;
    closes     = (edges_nxt >= enough_edges) || (samp_nxt >= sample_limit);
    open_nxt   = open_r;
    close_nxt.valid = 1'b0;
    close_nxt.dur   = time_ms - start_nxt;
    close_nxt.edges = edges_nxt;
    if (accept) begin
      if (!enable) begin
        open_nxt = 1'b0;
      end else begin
        open_nxt        = !closes;
        close_nxt.valid = closes;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r        <= 1'b0;
      prev_r        <= '0;
      edges_r       <= '0;
      samp_r        <= '0;
      start_r       <= '0;
      close_r.valid <= 1'b0;
    end else begin
      open_r        <= open_nxt;
      close_r.valid <= close_nxt.valid;
      if (accept && enable) begin
        prev_r  <= prev_nxt;
        edges_r <= edges_nxt;
        samp_r  <= samp_nxt;
        start_r <= start_nxt;
      end
    end
    close_r.dur   <= close_nxt.dur;
    close_r.edges <= close_nxt.edges;
  end

  assign close = close_r;

endmodule

FILE: rtl/core/edfdm_seq.sv
// result sequencer: divider scheduling, frequency compares, distance and push decision
`timescale 1ns / 1ps
module edfdm_seq
  import edfdm_pkg::*;
#(
  parameter int TIME_SCALE    = TIME_SCALE_DEF,
  parameter int NEAR_DISTANCE = NEAR_DISTANCE_DEF,
  parameter int FAR_DISTANCE  = FAR_DISTANCE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  win_close_t        close,
  input  seq_cfg_t          cfg,
  output div_req_t          div_req,
  input  div_stat_t         div_stat,
  output logic              idle,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DIST_W-1:0] out_distance_m,
  output logic [TIME_W-1:0] out_interval_ms,
  output logic              out_no_edges,
  output logic              out_in_range,
  output logic              out_distance_pushed
);

  localparam int SCALED_W = EDGE_W + $clog2(TIME_SCALE + 1);
  localparam int PROD_W   = FREQ_W + TIME_W;

  seq_state_t          state_r, state_nxt;
  logic [TIME_W-1:0]   dur_r, dur_nxt;
  logic [SCALED_W-1:0] scaled_r, scaled_nxt;
  logic                sel_hi_r, sel_hi_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [DIST_W-1:0]   meters_r, meters_nxt;
  logic [TIME_W-1:0]   interval_r, interval_nxt;
  logic                no_edges_r, no_edges_nxt;
  logic [DIST_W-1:0]   last_push_r, last_push_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0]   out_dist_r, out_dist_nxt;
  logic [TIME_W-1:0]   out_ivl_r, out_ivl_nxt;
  logic                out_noe_r, out_noe_nxt;
  logic                out_rng_r, out_rng_nxt;
  logic                out_push_r, out_push_nxt;

  logic                in_rng;
  logic [DIST_W-1:0]   diff;
  logic [DIST_W+3:0]   diff10;
  logic                push;
  logic [FREQ_W-1:0]   mul_op;

  always_comb begin
    state_nxt     = state_r;
    dur_nxt       = dur_r;
    scaled_nxt    = scaled_r;
    sel_hi_nxt    = sel_hi_r;
    prod_nxt      = prod_r;
    meters_nxt    = meters_r;
    interval_nxt  = interval_r;
    no_edges_nxt  = no_edges_r;
    last_push_nxt = last_push_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_dist_nxt  = out_dist_r;
    out_ivl_nxt   = out_ivl_r;
    out_noe_nxt   = out_noe_r;
    out_rng_nxt   = out_rng_r;
    out_push_nxt  = out_push_r;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(close.dur);
    div_req.divisor  = DIV_W'(close.edges);

    mul_op = sel_hi_r ? cfg.freq_hi : cfg.freq_lo;
    in_rng = meters_r <= cfg.signal_range;
    diff   = (last_push_r > meters_r) ? last_push_r - meters_r : meters_r - last_push_r;
    diff10 = {1'b0, diff, 3'b000} + {3'b000, diff, 1'b0};
    push   = in_rng && ((last_push_r == '0) || (diff10 >= {4'b0000, last_push_r}));

    case (state_r)
      S_IDLE: begin
        if (close.valid) begin
          dur_nxt    = close.dur;
          scaled_nxt = SCALED_W'(close.edges) * SCALED_W'(TIME_SCALE);
          sel_hi_nxt = 1'b1;
          if (close.edges != '0) begin
            div_req.start = 1'b1;
            no_edges_nxt  = 1'b0;
            state_nxt     = S_IVDIV;
          end else begin
            interval_nxt = '0;
            no_edges_nxt = 1'b1;
            state_nxt    = S_MUL;
          end
        end
      end
      S_IVDIV: begin
        if (div_stat.done) begin
          interval_nxt = div_stat.quotient[TIME_W-1:0];
          state_nxt    = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(mul_op) * PROD_W'(dur_r);
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (sel_hi_r) begin
          if (PROD_W'(scaled_r) > prod_r) begin
            meters_nxt = DIST_W'(NEAR_DISTANCE);
            state_nxt  = S_OUT;
          end else begin
            sel_hi_nxt = 1'b0;
            state_nxt  = S_MUL;
          end
        end else if (PROD_W'(scaled_r) < prod_r) begin
          meters_nxt = DIST_W'(FAR_DISTANCE);
          state_nxt  = S_OUT;
        end else if (dur_r != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(scaled_r);
          div_req.divisor  = DIV_W'(dur_r);
          state_nxt        = S_FDIV;
        end else begin
          meters_nxt = cfg.linear_offset;
          state_nxt  = S_OUT;
        end
      end
      S_FDIV: begin
        if (div_stat.done) begin
          if (div_stat.quotient > DIV_W'(cfg.linear_offset)) begin
            meters_nxt = '0;
          end else begin
            meters_nxt = cfg.linear_offset - div_stat.quotient[DIST_W-1:0];
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = in_rng ? meters_r : cfg.signal_range;
          out_ivl_nxt   = interval_r;
          out_noe_nxt   = no_edges_r;
          out_rng_nxt   = in_rng;
          out_push_nxt  = push;
          if (push) begin
            last_push_nxt = meters_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      last_push_r <= '0;
      sel_hi_r    <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_push_r <= last_push_nxt;
      sel_hi_r    <= sel_hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dur_r      <= dur_nxt;
    scaled_r   <= scaled_nxt;
    prod_r     <= prod_nxt;
    meters_r   <= meters_nxt;
    interval_r <= interval_nxt;
    no_edges_r <= no_edges_nxt;
    out_dist_r <= out_dist_nxt;
    out_ivl_r  <= out_ivl_nxt;
    out_noe_r  <= out_noe_nxt;
    out_rng_r  <= out_rng_nxt;
    out_push_r <= out_push_nxt;
  end

  assign idle                = state_r == S_IDLE;
  assign out_valid           = out_valid_r;
  assign out_distance_m      = out_dist_r;
  assign out_interval_ms     = out_ivl_r;
  assign out_no_edges        = out_noe_r;
  assign out_in_range        = out_rng_r;
  assign out_distance_pushed = out_push_r;

endmodule

FILE: rtl/core/edge_frequency_distance_meter_unit.sv
// top level of the edge frequency distance meter: configuration registers and wiring
`timescale 1ns / 1ps
// A sample that does not close its measurement window leaves the block ready, and
// samples can follow back to back. A sample that closes the window takes the block
// out of service until its result is loaded: the window update, the start, the
// interval division when the window saw edges, the one or two frequency compares,
// the frequency division when the frequency lies in the linear range, and the load
// of the result register, which waits while that register still holds an untaken
// result. Both divisions use the single 32-step restoring divider that they share.
// The result register holds one finished result while the next window is
// measured. No clearing pass follows reset.
module edge_frequency_distance_meter_unit
  import edfdm_pkg::*;
#(
  parameter int TIME_SCALE    = TIME_SCALE_DEF,
  parameter int NEAR_DISTANCE = NEAR_DISTANCE_DEF,
  parameter int FAR_DISTANCE  = FAR_DISTANCE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   in_sample,
  input  logic [TIME_W-1:0]     in_time_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DIST_W-1:0]     out_distance_m,
  output logic [TIME_W-1:0]     out_interval_ms,
  output logic                  out_no_edges,
  output logic                  out_in_range,
  output logic                  out_distance_pushed
);

  logic                enable_r;
  logic [SAMPLE_W-1:0] cutoff_r;
  logic [EDGE_W-1:0]   enough_r;
  logic [CNT_W-1:0]    max_samp_r;
  seq_cfg_t            seq_cfg_r;

  win_close_t          close;
  div_req_t            div_req;
  div_stat_t           div_stat;
  logic                seq_idle;
  logic                accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r                <= 1'b0;
      cutoff_r                <= SAMPLE_W'(512);
      enough_r                <= EDGE_W'(10);
      max_samp_r              <= CNT_W'(1000);
      seq_cfg_r.freq_hi       <= FREQ_W'(100);
      seq_cfg_r.freq_lo       <= FREQ_W'(1);
      seq_cfg_r.linear_offset <= DIST_W'(1000);
      seq_cfg_r.signal_range  <= DIST_W'(1000);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ENABLE:        enable_r                <= cfg_data[0];
        CFG_CUTOFF:        cutoff_r                <= cfg_data[SAMPLE_W-1:0];
        CFG_ENOUGH_EDGES:  enough_r                <= cfg_data[EDGE_W-1:0];
        CFG_SAMPLE_LIMIT:  max_samp_r              <= cfg_data[CNT_W-1:0];
        CFG_FREQ_HI:       seq_cfg_r.freq_hi       <= cfg_data[FREQ_W-1:0];
        CFG_FREQ_LO:       seq_cfg_r.freq_lo       <= cfg_data[FREQ_W-1:0];
        CFG_LINEAR_OFFSET: seq_cfg_r.linear_offset <= cfg_data[DIST_W-1:0];
        CFG_SIGNAL_RANGE:  seq_cfg_r.signal_range  <= cfg_data[DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready = seq_idle && !close.valid;
  assign accept   = in_valid && in_ready;

  edfdm_window u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .sample       (in_sample),
    .time_ms      (in_time_ms),
    .enable       (enable_r),
    .cutoff       (cutoff_r),
    .enough_edges (enough_r),
    .sample_limit (max_samp_r),
    .close        (close)
  );

  edfdm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .stat  (div_stat)
  );

  edfdm_seq #(
    .TIME_SCALE    (TIME_SCALE),
    .NEAR_DISTANCE (NEAR_DISTANCE),
    .FAR_DISTANCE  (FAR_DISTANCE)
  ) u_seq (
    .clk                 (clk),
    .rst_n               (rst_n),
    .close               (close),
    .cfg                 (seq_cfg_r),
    .div_req             (div_req),
    .div_stat            (div_stat),
    .idle                (seq_idle),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_distance_m      (out_distance_m),
    .out_interval_ms     (out_interval_ms),
    .out_no_edges        (out_no_edges),
    .out_in_range        (out_in_range),
    .out_distance_pushed (out_distance_pushed)
  );

endmodule

FILE: rtl/core/edfdm_checker.sv
// port level checks of the edge frequency distance meter and their binding
`timescale 1ns / 1ps
module edfdm_checker
  import edfdm_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DIST_W-1:0] out_distance_m,
  input logic [TIME_W-1:0] out_interval_ms,
  input logic              out_no_edges,
  input logic              out_in_range,
  input logic              out_distance_pushed
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_distance_m) && $stable(out_interval_ms))
    else $error("result payload changed while stalled");

  a_no_edge_ivl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_edges |-> out_interval_ms == '0)
    else $error("interval nonzero for a window without edges");

  a_push_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_distance_pushed |-> out_in_range)
    else $error("out of range distance marked pushed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind edge_frequency_distance_meter_unit edfdm_checker u_chk (.*);

FILE: sim/edge_frequency_distance_meter_unit_test.sv
// testbench of the edge frequency distance meter: random and directed samples, scoreboard
`timescale 1ns / 1ps
module edge_frequency_distance_meter_unit_test;
  import edfdm_pkg::*;

  localparam int RANDOM_ITEMS = 1650;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [DIST_W-1:0] distance_m;
    logic [TIME_W-1:0] interval_ms;
    logic              no_edges;
    logic              in_range;
    logic              distance_pushed;
  } reading_t;

  class meter_tracker;
    bit                   enable_r;
    logic [SAMPLE_W-1:0]  cut_level;
    logic [EDGE_W-1:0]    edge_goal;
    logic [CNT_W-1:0]     sample_goal;
    longint unsigned      f_high, f_low, lin_offset, range_limit;
    logic [SAMPLE_W-1:0]  last_level;
    logic [EDGE_W-1:0]    edge_cnt;
    logic [CNT_W-1:0]     sample_cnt;
    logic [TIME_W-1:0]    win_start;
    bit                   win_open;
    longint unsigned      last_pushed;
    reading_t             expected_readings[$];
    int                   mismatches, samples_seen, readings_seen;
    int                   pushed_seen, beyond_seen, flat_seen;

    function new();
      enable_r    = 0;
      cut_level   = 512;
      edge_goal   = 10;
      sample_goal = 1000;
      f_high      = 100;
      f_low       = 1;
      lin_offset  = 1000;
      range_limit = 1000;
      last_level  = 0;
      edge_cnt    = 0;
      sample_cnt  = 0;
      win_start   = 0;
      win_open    = 0;
      last_pushed = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_ENABLE:        enable_r    = v[0];
        CFG_CUTOFF:        cut_level   = v[SAMPLE_W-1:0];
        CFG_ENOUGH_EDGES:  edge_goal   = v[EDGE_W-1:0];
        CFG_SAMPLE_LIMIT:  sample_goal = v;
        CFG_FREQ_HI:       f_high      = 64'(v);
        CFG_FREQ_LO:       f_low       = 64'(v);
        CFG_LINEAR_OFFSET: lin_offset  = 64'(v);
        CFG_SIGNAL_RANGE:  range_limit = 64'(v);
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    function void take_sample(logic [SAMPLE_W-1:0] s, logic [TIME_W-1:0] t);
      logic [TIME_W-1:0] span;
      longint unsigned dur, scaled, freq, meters, diff;
      reading_t r;
      if (!enable_r) begin
        win_open = 0;
        return;
      end
      samples_seen++;
      if (!win_open) begin
        win_open   = 1;
        edge_cnt   = 0;
        sample_cnt = 0;
        last_level = 0;
        win_start  = t;
      end
      if (s < cut_level && last_level >= cut_level && edge_cnt < 8'hFF) edge_cnt++;
      last_level = s;
      if (sample_cnt < 16'hFFFF) sample_cnt++;
      if (edge_cnt < edge_goal && sample_cnt < sample_goal) return;
      // window closes on this sample
      win_open = 0;
      span     = t - win_start;
      dur      = 64'(span);
      scaled   = 64'(edge_cnt);
      scaled   = scaled * 64'(TIME_SCALE_DEF);
      r        = '0;
      r.no_edges = (edge_cnt == 0);
      if (edge_cnt != 0) r.interval_ms = TIME_W'(dur / 64'(edge_cnt));
      if (scaled > f_high * dur) begin
        meters = 64'(NEAR_DISTANCE_DEF);
      end else if (scaled < f_low * dur) begin
        meters = 64'(FAR_DISTANCE_DEF);
      end else begin
        freq   = (dur != 0) ? scaled / dur : 0;
        meters = (freq > lin_offset) ? 0 : lin_offset - freq;
      end
      if (meters <= range_limit) begin
        diff         = (last_pushed > meters) ? last_pushed - meters : meters - last_pushed;
        r.distance_m = meters[DIST_W-1:0];
        r.in_range   = 1;
        if (last_pushed == 0 || diff * 10 >= last_pushed) begin
          r.distance_pushed = 1;
          last_pushed       = meters;
          pushed_seen++;
        end
      end else begin
        r.distance_m = range_limit[DIST_W-1:0];
        beyond_seen++;
      end
      if (r.no_edges) flat_seen++;
      expected_readings.push_back(r);
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (expected_readings.size() == 0) begin
        $error("reading with none expected: distance_m %0d interval_ms %0d",
               got.distance_m, got.interval_ms);
        mismatches++;
        return;
      end
      want = expected_readings.pop_front();
      readings_seen++;
      if (got.distance_m !== want.distance_m) begin
        $error("distance_m expected %0d got %0d", want.distance_m, got.distance_m);
        mismatches++;
      end
      if (got.interval_ms !== want.interval_ms) begin
        $error("interval_ms expected %0d got %0d", want.interval_ms, got.interval_ms);
        mismatches++;
      end
      if (got.no_edges !== want.no_edges) begin
        $error("no_edges expected %0d got %0d", want.no_edges, got.no_edges);
        mismatches++;
      end
      if (got.in_range !== want.in_range) begin
        $error("in_range expected %0d got %0d", want.in_range, got.in_range);
        mismatches++;
      end
      if (got.distance_pushed !== want.distance_pushed) begin
        $error("distance_pushed expected %0d got %0d", want.distance_pushed,
               got.distance_pushed);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   in_sample;
  logic [TIME_W-1:0]     in_time_ms;
  logic                  out_valid;
  logic                  out_ready;
  logic [DIST_W-1:0]     out_distance_m;
  logic [TIME_W-1:0]     out_interval_ms;
  logic                  out_no_edges;
  logic                  out_in_range;
  logic                  out_distance_pushed;

  meter_tracker sb;
  bit  sender_idle_on   = 1;
  bit  receiver_idle_on = 1;
  bit  hold_request     = 0;
  int  random_items     = 0;
  int  reg_writes       = 0;
  int  cycle_count      = 0;

  edge_frequency_distance_meter_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_sample           (in_sample),
    .in_time_ms          (in_time_ms),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_distance_m      (out_distance_m),
    .out_interval_ms     (out_interval_ms),
    .out_no_edges        (out_no_edges),
    .out_in_range        (out_in_range),
    .out_distance_pushed (out_distance_pushed)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_reading('{out_distance_m, out_interval_ms, out_no_edges, out_in_range,
                         out_distance_pushed});
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 0;
        out_ready    = 0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready = !(receiver_idle_on && $urandom_range(99) < 13);
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we    = 1;
    cfg_index = idx;
    cfg_data  = v;
    @(negedge clk);
    cfg_we = 0;
    sb.set_reg(idx, v);
    reg_writes++;
  endtask

  task automatic send(logic [SAMPLE_W-1:0] s, logic [TIME_W-1:0] t);
    while (sender_idle_on && $urandom_range(99) < 13) begin
      @(negedge clk);
      in_valid = 0;
    end
    @(negedge clk);
    in_valid   = 1;
    in_sample  = s;
    in_time_ms = t;
    do @(posedge clk); while (!in_ready);
    sb.take_sample(s, t);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int phase, n_items, step_max, cut, noise_pct, lo, hi;
    int s;
    bit enabled, high_side;
    logic [TIME_W-1:0] clock_ms, t;

    sb         = new();
    rst_n      = 0;
    cfg_we     = 0;
    cfg_index  = CFG_ENABLE;
    cfg_data   = 0;
    in_valid   = 0;
    in_sample  = 0;
    in_time_ms = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // disabled after reset: samples are dropped
    send(700, 5);
    send(100, 9);
    settle();
    write_reg(CFG_ENABLE, 1);
    write_reg(CFG_ENOUGH_EDGES, 2);
    send(1023, 100);
    send(0, 110);
    send(1023, 120);
    send(0, 130);
    // zero duration with edges
    send(1023, 500);
    send(0, 500);
    send(600, 500);
    send(511, 500);
    settle();
    // no edges, timestamp wraps inside the window
    write_reg(CFG_SAMPLE_LIMIT, 3);
    send(300, 32'hFFFF_FFF0);
    send(1023, 32'hFFFF_FFFF);
    send(700, 32'h0000_0010);
    settle();
    // zero duration without edges, distance unchanged so not pushed
    write_reg(CFG_SAMPLE_LIMIT, 1);
    send(0, 32'h8000_0000);
    settle();
    // zero edge and sample goals
    write_reg(CFG_ENOUGH_EDGES, 0);
    write_reg(CFG_SAMPLE_LIMIT, 0);
    send(1023, 7);
    settle();
    // negative linear distance saturates
    write_reg(CFG_ENOUGH_EDGES, 1);
    write_reg(CFG_SAMPLE_LIMIT, 65535);
    write_reg(CFG_FREQ_HI, 65535);
    write_reg(CFG_FREQ_LO, 0);
    write_reg(CFG_LINEAR_OFFSET, 10);
    write_reg(CFG_CUTOFF, 1023);
    send(1023, 0);
    send(1022, 3);
    settle();
    // beyond signal range
    write_reg(CFG_LINEAR_OFFSET, 65535);
    write_reg(CFG_SIGNAL_RANGE, 100);
    write_reg(CFG_CUTOFF, 0);
    write_reg(CFG_SAMPLE_LIMIT, 2);
    send(0, 0);
    send(1023, 1000);

    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      settle();
      sender_idle_on   = (phase != 2);
      receiver_idle_on = (phase != 2);
      enabled          = (phase % 7 != 5);
      noise_pct        = 15;
      n_items          = $urandom_range(80, 20);

      case ($urandom_range(9))
        0: cut = 0;
        1: cut = 1023;
        default: cut = $urandom_range(1023, 1);
      endcase
      write_reg(CFG_ENABLE, CFG_DATA_W'(enabled));

      if (phase == 6) begin
        // longest window: full edge goal, widest sample goal
        noise_pct = 0;
        n_items   = 520;
        cut       = 1023;
        write_reg(CFG_ENOUGH_EDGES, 255);
        write_reg(CFG_SAMPLE_LIMIT, 65535);
      end else if (phase == 4) begin
        write_reg(CFG_ENOUGH_EDGES, 1);
        write_reg(CFG_SAMPLE_LIMIT, 4);
      end else begin
        case ($urandom_range(19))
          0: write_reg(CFG_ENOUGH_EDGES, 0);
          1: write_reg(CFG_ENOUGH_EDGES, 1);
          default: write_reg(CFG_ENOUGH_EDGES, CFG_DATA_W'($urandom_range(8, 1)));
        endcase
        case ($urandom_range(19))
          0: write_reg(CFG_SAMPLE_LIMIT, 0);
          1: write_reg(CFG_SAMPLE_LIMIT, 65535);
          2: write_reg(CFG_SAMPLE_LIMIT, 1);
          default: write_reg(CFG_SAMPLE_LIMIT, CFG_DATA_W'($urandom_range(40, 2)));
        endcase
      end
      write_reg(CFG_CUTOFF, CFG_DATA_W'(cut));

      lo = $urandom_range(60);
      hi = lo + $urandom_range(1000);
      case ($urandom_range(9))
        0: begin lo = 0; hi = 65535; end
        1: begin lo = 65535; hi = 0; end
        2: hi = 0;
        default: ;
      endcase
      write_reg(CFG_FREQ_HI, CFG_DATA_W'(hi));
      write_reg(CFG_FREQ_LO, CFG_DATA_W'(lo));
      case ($urandom_range(9))
        0: write_reg(CFG_LINEAR_OFFSET, 0);
        1: write_reg(CFG_LINEAR_OFFSET, 65535);
        default: write_reg(CFG_LINEAR_OFFSET, CFG_DATA_W'($urandom_range(1200)));
      endcase
      case ($urandom_range(9))
        0: write_reg(CFG_SIGNAL_RANGE, 0);
        1: write_reg(CFG_SIGNAL_RANGE, 65535);
        default: write_reg(CFG_SIGNAL_RANGE, CFG_DATA_W'($urandom_range(1500)));
      endcase

      case ($urandom_range(6))
        0: step_max = 0;
        1: step_max = 1;
        2: step_max = 4;
        3: step_max = 16;
        4: step_max = 64;
        5: step_max = 1000;
        default: step_max = 100000;
      endcase
      if (phase == 6) step_max = 4;

      if (phase == 4) hold_request = 1;
      clock_ms  = $urandom();
      high_side = 1;
      for (int i = 0; i < n_items; i++) begin
        if (cut != 0 && $urandom_range(99) >= noise_pct) begin
          s = high_side ? $urandom_range(1023, cut) : $urandom_range(cut - 1, 0);
          if (noise_pct == 0 || $urandom_range(9) != 0) high_side = !high_side;
        end else begin
          s = $urandom_range(1023);
        end
        clock_ms = clock_ms + $urandom_range(step_max);
        t = ($urandom_range(49) == 0) ? $urandom() : clock_ms;
        send(SAMPLE_W'(s), t);
        if (enabled) random_items++;
      end
      phase++;
    end
    settle();

    $display("run covered %0d enabled samples and %0d readings: %0d pushed, %0d beyond range,",
             sb.samples_seen, sb.readings_seen, sb.pushed_seen, sb.beyond_seen);
    $display("%0d windows without edges, %0d setting phases, %0d register writes",
             sb.flat_seen, phase, reg_writes);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/edfdm_pkg.sv
rtl/core/edfdm_div.sv
rtl/core/edfdm_window.sv
rtl/core/edfdm_seq.sv
rtl/core/edge_frequency_distance_meter_unit.sv
rtl/core/edfdm_checker.sv
sim/edge_frequency_distance_meter_unit_test.sv
